/* rtl/core/bit_column_mask_compaction_unit_defines.svh */
// assertion macros shared by the bit column mask compaction rtl
`ifndef BIT_COLUMN_MASK_COMPACTION_UNIT_DEFINES_SVH
`define BIT_COLUMN_MASK_COMPACTION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while arst_n is low
`define BCMC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bcmc: assertion failed");
// next-cycle implication, sampled on clk, off while arst_n is low
`define BCMC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bcmc: assertion failed");
`else
`define BCMC_ASSERT_IMP(lbl, ante, cons)
`define BCMC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/bcmc_pkg.sv */
// shared constants for the bit column mask compaction unit
package bcmc_pkg;

	// fixed payload widths of the channels
	localparam int unsigned DATA_W = 64;
	localparam int unsigned CNT_W  = 7;

endpackage

/* rtl/core/bcmc_in_if.sv */
// input channel: one data chunk with its mask, bit count and last flag per beat
interface bcmc_in_if;

	logic                          valid;
	logic                          ready;
	logic [bcmc_pkg::DATA_W-1:0]   data_word;
	logic [bcmc_pkg::DATA_W-1:0]   mask_word;
	logic [bcmc_pkg::CNT_W-1:0]    valid_bits;
	logic                          last_chunk;

	modport source (
		output valid, data_word, mask_word, valid_bits, last_chunk,
		input  ready
	);

	modport sink (
		input  valid, data_word, mask_word, valid_bits, last_chunk,
		output ready
	);

endinterface

/* rtl/core/bcmc_out_if.sv */
// output channel: one packed word with its bit count and last mark per beat
interface bcmc_out_if;

	logic                          valid;
	logic                          ready;
	logic [bcmc_pkg::DATA_W-1:0]   packed_word;
	logic [bcmc_pkg::CNT_W-1:0]    bit_count;
	logic                          last_word;

	modport source (
		output valid, packed_word, bit_count, last_word,
		input  ready
	);

	modport sink (
		input  valid, packed_word, bit_count, last_word,
		output ready
	);

endinterface

/* rtl/core/bcmc_front.sv */
// front pipeline: clips the chunk, marks kept bits and compresses them to bit 0
module bcmc_front #(
	parameter int unsigned W  = 64,
	parameter int unsigned CW = 7,
	parameter int unsigned SW = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	bcmc_in_if.sink           chunk,
	input  logic              q_full,
	output logic              push,
	output logic [W-1:0]      push_bits,
	output logic [CW-1:0]     push_cnt,
	output logic              push_last
);

	localparam int unsigned CNTW = bcmc_pkg::CNT_W;
	localparam int unsigned HALF = SW / 2;

	// kept bits travel with the distance each one still has to move down
	typedef struct packed {
		logic [W-1:0]          bits;
		logic [W-1:0]          keep;
		logic [W-1:0][SW-1:0]  amt;
	} elems_t;

	// one level of the compress network: move by 2**k where bit k of the distance is set
	function automatic elems_t shift_stage(elems_t e, int k);
		elems_t r;
		int     s;
		int     src;
		r = '0;
		s = 1 << k;
		for (int p = 0; p < W; p++) begin
			src = p + s;
			if (e.keep[p] && !e.amt[p][k]) begin
				r.bits[p] = e.bits[p];
				r.keep[p] = 1'b1;
				r.amt[p]  = e.amt[p];
			end else if (src < W) begin
				if (e.keep[src] && e.amt[src][k]) begin
					r.bits[p] = e.bits[src];
					r.keep[p] = 1'b1;
					r.amt[p]  = e.amt[src];
				end
			end
		end
		return r;
	endfunction

	logic              en;
	logic [CW-1:0]     vclip;
	logic [W-1:0]      keep;
	logic [SW-1:0]     pre [W];
	logic [SW-1:0]     nxt [W];
	logic [CW-1:0]     kept;
	elems_t            e_in;
	elems_t            e_mid;
	elems_t            e_out;

	logic              val_s1;
	elems_t            e_s1;
	logic [CW-1:0]     cnt_s1;
	logic              last_s1;
	logic              val_s2;
	elems_t            e_s2;
	logic [CW-1:0]     cnt_s2;
	logic              last_s2;
	logic              val_s3;
	logic [W-1:0]      bits_s3;
	logic [CW-1:0]     cnt_s3;
	logic              last_s3;

	// whole pipeline moves unless the last stage is stuck on a full queue
	assign en          = !val_s3 || !q_full;
	assign chunk.ready = en;
	assign push        = val_s3 && !q_full;
	assign push_bits   = bits_s3;
	assign push_cnt    = cnt_s3;
	assign push_last   = last_s3;

	// clip the count and mark kept bits
	always_comb begin
		if (chunk.valid_bits > CNTW'(W)) begin
			vclip = CW'(W);
		end else begin
			vclip = chunk.valid_bits[CW-1:0];
		end
		for (int i = 0; i < W; i++) begin
			keep[i] = chunk.mask_word[i] && (CW'(i) < vclip);
		end
	end

	// exclusive prefix count of dropped bits, log-depth scan
	always_comb begin
		for (int i = 0; i < W; i++) begin
			if (i == 0) begin
				pre[i] = '0;
			end else begin
				pre[i] = SW'(!keep[i-1]);
			end
		end
		for (int l = 0; l < SW; l++) begin
			nxt = pre;
			for (int i = 0; i < W; i++) begin
				if (i >= (1 << l)) begin
					pre[i] = nxt[i] + nxt[i - (1 << l)];
				end
			end
		end
		kept = CW'(W) - (CW'(pre[W-1]) + CW'(!keep[W-1]));
	end

	// element set entering the network
	always_comb begin
		e_in.bits = chunk.data_word[W-1:0] & keep;
		e_in.keep = keep;
		for (int i = 0; i < W; i++) begin
			e_in.amt[i] = pre[i];
		end
	end

	// low half of the distance bits
	always_comb begin
		e_mid = e_s1;
		for (int k = 0; k < HALF; k++) begin
			e_mid = shift_stage(e_mid, k);
		end
	end

	// high half of the distance bits
	always_comb begin
		e_out = e_s2;
		for (int k = HALF; k < SW; k++) begin
			e_out = shift_stage(e_out, k);
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
			val_s2 <= 1'b0;
			val_s3 <= 1'b0;
		end else if (en) begin
			val_s1 <= chunk.valid;
			val_s2 <= val_s1;
			val_s3 <= val_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			e_s1    <= e_in;
			cnt_s1  <= kept;
			last_s1 <= chunk.last_chunk;
			e_s2    <= e_mid;
			cnt_s2  <= cnt_s1;
			last_s2 <= last_s1;
			bits_s3 <= e_out.bits;
			cnt_s3  <= cnt_s2;
			last_s3 <= last_s2;
		end
	end

endmodule

/* rtl/core/bcmc_queue.sv */
// small register queue between the compress pipeline and the packer
`include "bit_column_mask_compaction_unit_defines.svh"

module bcmc_queue #(
	parameter int unsigned WIDTH = 72,
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [WIDTH-1:0]  push_data,
	input  logic              pop,
	output logic [WIDTH-1:0]  pop_data,
	output logic              full,
	output logic              empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [NW-1:0]     count_q;

	assign full     = (count_q == NW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`BCMC_ASSERT_IMP(a_push_has_room, push, count_q < NW'(DEPTH))
	`BCMC_ASSERT_IMP(a_pop_has_entry, pop, count_q != '0)

endmodule

/* rtl/core/bcmc_back.sv */
// packer: appends compressed chunks to the pending word and drives result beats
`include "bit_column_mask_compaction_unit_defines.svh"

module bcmc_back #(
	parameter int unsigned W  = 64,
	parameter int unsigned CW = 7,
	parameter int unsigned SW = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  logic [W-1:0]      q_bits,
	input  logic [CW-1:0]     q_cnt,
	input  logic              q_last,
	output logic              q_pop,
	bcmc_out_if.source        result
);

	localparam int unsigned TW   = $clog2(2 * W);
	localparam int unsigned DW   = bcmc_pkg::DATA_W;
	localparam int unsigned CNTW = bcmc_pkg::CNT_W;

	logic [W-1:0]      pend_q;
	logic [SW-1:0]     pend_cnt_q;
	logic              out_valid_q;
	logic [W-1:0]      out_word_q;
	logic [CW-1:0]     out_cnt_q;
	logic              out_last_q;
	logic              hold_valid_q;
	logic [W-1:0]      hold_word_q;
	logic [SW-1:0]     hold_cnt_q;

	logic              out_free;
	logic [2*W-1:0]    joined;
	logic [W-1:0]      lo;
	logic [W-1:0]      hi;
	logic [TW-1:0]     total;
	logic              full;
	logic [SW-1:0]     rem;
	logic              r0_v;
	logic [CW-1:0]     r0_cnt;
	logic              r0_last;
	logic              r1_v;

	assign out_free = !out_valid_q || result.ready;
	assign q_pop    = q_valid && !hold_valid_q && out_free;

	// append the chunk above the pending bits
	always_comb begin
		joined = {{W{1'b0}}, pend_q} | ({{W{1'b0}}, q_bits} << pend_cnt_q);
		lo     = joined[W-1:0];
		hi     = joined[2*W-1:W];
		total  = TW'(pend_cnt_q) + TW'(q_cnt);
		full   = (total >= TW'(W));
		if (full) begin
			rem = SW'(total - TW'(W));
		end else begin
			rem = SW'(total);
		end
	end

	// results caused by this beat: a full word, a final partial word, or both
	always_comb begin
		r0_v    = full || q_last;
		r1_v    = full && q_last && (rem != '0);
		if (full) begin
			r0_cnt  = CW'(W);
			r0_last = q_last && (rem == '0);
		end else begin
			r0_cnt  = CW'(rem);
			r0_last = 1'b1;
		end
	end

	// output slot, second-result hold control and pending word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
			pend_cnt_q   <= '0;
			pend_q       <= '0;
		end else begin
			if (hold_valid_q && out_free) begin
				out_valid_q  <= 1'b1;
				hold_valid_q <= 1'b0;
			end else if (q_pop) begin
				out_valid_q  <= r0_v;
				hold_valid_q <= r1_v;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				pend_cnt_q <= q_last ? '0 : rem;
				if (q_last) begin
					pend_q <= '0;
				end else if (full) begin
					pend_q <= hi;
				end else begin
					pend_q <= lo;
				end
			end
		end
	end

	// output and hold payloads
	always_ff @(posedge clk) begin
		if (hold_valid_q && out_free) begin
			out_word_q <= hold_word_q;
			out_cnt_q  <= CW'(hold_cnt_q);
			out_last_q <= 1'b1;
		end else if (q_pop) begin
			out_word_q  <= lo;
			out_cnt_q   <= r0_cnt;
			out_last_q  <= r0_last;
			hold_word_q <= hi;
			hold_cnt_q  <= rem;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.packed_word = DW'(out_word_q);
	assign result.bit_count   = CNTW'(out_cnt_q);
	assign result.last_word   = out_last_q;

	`BCMC_ASSERT_IMP(a_hold_behind_out, hold_valid_q, out_valid_q)
	`BCMC_ASSERT_IMP(a_pop_gated, q_pop, q_valid && !hold_valid_q)
	`BCMC_ASSERT_NXT(a_last_clears_pending, q_pop && q_last, pend_cnt_q == '0)

endmodule

/* rtl/core/bit_column_mask_compaction_unit.sv */
// top level of the bit column mask compaction unit
//
//  channel  dir  modport  beat contents
//  chunk    in   sink     data_word, mask_word, valid_bits, last_chunk
//  result   out  source   packed_word, bit_count, last_word
//
// one chunk accepted per cycle unless stalled; stages s1 to s3 carry it to the packer queue
// the packer takes one queue entry per cycle while no second result is held and the output
//   is free; a last chunk that closes a full word with a remainder yields two result beats
// reset clears the pipeline valids, queue pointers, pending word and count; no clearing pass
// chunk.ready drops only while the third compress stage holds a beat and the queue is full
module bit_column_mask_compaction_unit #(
	parameter int unsigned WORD_BITS   = 64,
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	bcmc_in_if.sink     chunk,
	bcmc_out_if.source  result
);

	localparam int unsigned W  = WORD_BITS;
	localparam int unsigned CW = $clog2(W + 1);
	localparam int unsigned SW = $clog2(W);
	localparam int unsigned EW = W + CW + 1;

	logic           push;
	logic [W-1:0]   push_bits;
	logic [CW-1:0]  push_cnt;
	logic           push_last;
	logic           q_full;
	logic           q_empty;
	logic           q_pop;
	logic [EW-1:0]  q_data;

	// compress pipeline
	bcmc_front #(
		.W  (W),
		.CW (CW),
		.SW (SW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.chunk     (chunk),
		.q_full    (q_full),
		.push      (push),
		.push_bits (push_bits),
		.push_cnt  (push_cnt),
		.push_last (push_last)
	);

	// decoupling queue
	bcmc_queue #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_last, push_cnt, push_bits}),
		.pop       (q_pop),
		.pop_data  (q_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	// word packer
	bcmc_back #(
		.W  (W),
		.CW (CW),
		.SW (SW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (!q_empty),
		.q_bits  (q_data[W-1:0]),
		.q_cnt   (q_data[W+CW-1:W]),
		.q_last  (q_data[EW-1]),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule

/* tb/bit_column_mask_compaction_unit_tb.sv */
// self-checking testbench for the bit column mask compaction unit
module bit_column_mask_compaction_unit_tb;

	localparam int unsigned WORD_BITS    = 64;
	localparam int          RANDOM_ITEMS = 950;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          QUIET_LIMIT  = 3000;
	localparam int          TAIL_CYCLES  = 20;
	localparam int          MAX_REPORTS  = 10;

	// one chunk beat as queued for the driver
	typedef struct packed {
		logic [bcmc_pkg::DATA_W-1:0] data;
		logic [bcmc_pkg::DATA_W-1:0] mask;
		logic [bcmc_pkg::CNT_W-1:0]  count;
		bit                          last;
		int                          gap;
		bit                          drain;     // hold back until every result is in
		bit                          stall_rx;  // starts a long receiver hold-off
	} chunk_beat_t;

	// one packed result beat
	typedef struct packed {
		logic [bcmc_pkg::DATA_W-1:0] word;
		int                          count;
		bit                          last;
	} packed_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	bcmc_in_if  chunk_ch ();
	bcmc_out_if result_ch ();

	bit_column_mask_compaction_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chunk  (chunk_ch),
		.result (result_ch)
	);

	always #4 clk = ~clk;

	chunk_beat_t       chunk_q[$];
	packed_beat_t      expected_words[$];

	// accumulator of kept bits not yet emitted
	logic [bcmc_pkg::DATA_W-1:0] acc_word  = '0;
	int                          acc_count = 0;

	int errors       = 0;
	int words_seen   = 0;
	int quiet_cycles = 0;
	bit hold_req     = 1'b0;

	// appends the kept bits of one chunk and queues the words it completes
	function automatic void pack_chunk(input chunk_beat_t c);
		logic [bcmc_pkg::DATA_W-1:0] lo;
		logic [bcmc_pkg::DATA_W-1:0] hi;
		int                          fill;
		int                          n_valid;
		int                          produced;
		packed_beat_t                r;
		lo       = acc_word;
		hi       = '0;
		fill     = acc_count;
		produced = 0;
		n_valid  = (c.count > WORD_BITS) ? WORD_BITS : c.count;
		for (int i = 0; i < n_valid; i++) begin
			if (c.mask[i]) begin
				if (fill < WORD_BITS)
					lo[fill] = c.data[i];
				else
					hi[fill - WORD_BITS] = c.data[i];
				fill++;
			end
		end
		// full word out; it closes the column only if nothing is left over
		if (fill >= WORD_BITS) begin
			fill    -= WORD_BITS;
			r.word   = lo;
			r.count  = WORD_BITS;
			r.last   = c.last && (fill == 0);
			expected_words.push_back(r);
			produced++;
			lo = hi;
		end
		// remainder or empty marker on the last chunk
		if (c.last) begin
			if (fill > 0 || produced == 0) begin
				r.word  = (fill > 0) ? lo : '0;
				r.count = fill;
				r.last  = 1'b1;
				expected_words.push_back(r);
			end
			acc_word  = '0;
			acc_count = 0;
		end else begin
			acc_word  = lo;
			acc_count = fill;
		end
	endfunction

	function automatic logic [bcmc_pkg::DATA_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [bcmc_pkg::DATA_W-1:0] rand_mask(input int style);
		case (style)
			4, 5:    return rand_word() & rand_word() & rand_word();
			6, 7:    return rand_word() | rand_word();
			8:       return '1;
			9:       return '0;
			default: return rand_word();
		endcase
	endfunction

	task automatic add_chunk(input logic [bcmc_pkg::DATA_W-1:0] data,
			input logic [bcmc_pkg::DATA_W-1:0] mask,
			input int count, input bit last, input int gap, input bit drain, input bit stall);
		chunk_beat_t c;
		c.data     = data;
		c.mask     = mask;
		c.count    = count[bcmc_pkg::CNT_W-1:0];
		c.last     = last;
		c.gap      = gap;
		c.drain    = drain;
		c.stall_rx = stall;
		chunk_q.push_back(c);
	endtask

	// stimulus: directed corner cases, then random columns
	initial begin : build_stimulus
		int n_cols;
		int n_chunks;
		int mask_style;
		int burst_left;
		int cnt;
		bit calm;
		bit drain;
		bit stall;
		// full words of ones and zeros, the second closing its column exactly
		add_chunk('1, '1, 64, 1'b0, 0, 1'b0, 1'b0);
		add_chunk('0, '1, 64, 1'b1, 0, 1'b0, 1'b0);
		// column with nothing kept
		add_chunk(rand_word(), '0, 64, 1'b1, 2, 1'b0, 1'b0);
		// zero counts keep nothing, then an empty last
		add_chunk('1, '1, 0, 1'b0, 0, 1'b0, 1'b0);
		add_chunk('1, '1, 0, 1'b1, 0, 1'b0, 1'b0);
		// counts above the word size are clipped
		add_chunk(rand_word(), '1, 127, 1'b0, 1, 1'b0, 1'b0);
		add_chunk(rand_word(), rand_word(), 65, 1'b1, 0, 1'b0, 1'b0);
		// short chunk mid column, then a last chunk giving a full word plus remainder
		add_chunk(rand_word(), '1, 5, 1'b0, 3, 1'b0, 1'b0);
		add_chunk(rand_word(), '1, 64, 1'b1, 0, 1'b0, 1'b0);
		// short chunks that fill a word exactly on the last one
		add_chunk(rand_word(), '1, 30, 1'b0, 0, 1'b0, 1'b0);
		add_chunk(rand_word(), '1, 34, 1'b1, 0, 1'b0, 1'b0);
		// alternating patterns and single bit chunks
		add_chunk({32{2'b01}}, {32{2'b10}}, 64, 1'b0, 16, 1'b0, 1'b0);
		add_chunk({32{2'b10}}, {32{2'b01}}, 64, 1'b0, 0, 1'b0, 1'b0);
		add_chunk(rand_word(), '1, 1, 1'b1, 0, 1'b0, 1'b0);
		add_chunk('1, '1, 63, 1'b0, 0, 1'b0, 1'b0);
		add_chunk('1, '1, 64, 1'b1, 0, 1'b0, 1'b0);
		add_chunk(rand_word(), 64'h8000_0000_0000_0001, 64, 1'b1, 5, 1'b0, 1'b0);

		// random columns, mostly well formed, some with odd counts
		n_cols     = 0;
		burst_left = 0;
		while (chunk_q.size() < RANDOM_ITEMS) begin
			n_cols++;
			n_chunks   = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
				: $urandom_range(1, 8);
			mask_style = $urandom_range(0, 9);
			calm       = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < n_chunks; k++) begin
				drain = (k == 0) && (n_cols % 40 == 10);
				stall = (k == 0) && (n_cols % 40 == 11);
				if (stall)
					burst_left = 40;
				cnt = (k < n_chunks - 1) ? 64 : $urandom_range(1, 64);
				if ($urandom_range(0, 11) == 0)
					cnt = $urandom_range(0, 127);
				add_chunk(rand_word(), rand_mask(mask_style), cnt, k == n_chunks - 1,
					(calm || burst_left > 0) ? 0 : $urandom_range(0, 16), drain, stall);
				if (burst_left > 0)
					burst_left--;
			end
		end
	end

	// chunk driver
	chunk_beat_t cur;
	chunk_beat_t offered;
	bit          have_cur = 1'b0;
	int          gap_left = 0;

	always @(posedge clk) begin : drive_chunks
		bit stall_now;
		stall_now = 1'b0;
		if (!arst_n) begin
			chunk_ch.valid <= 1'b0;
		end else begin
			if (chunk_ch.valid && chunk_ch.ready)
				pack_chunk(offered);
			if (!chunk_ch.valid || chunk_ch.ready) begin
				// pick the next beat unless it must wait for the output to drain
				if (!have_cur && chunk_q.size() > 0
						&& !(chunk_q[0].drain && expected_words.size() > 0)) begin
					cur      = chunk_q.pop_front();
					have_cur = 1'b1;
					gap_left = cur.gap;
				end
				if (have_cur && gap_left == 0) begin
					offered   = cur;
					have_cur  = 1'b0;
					stall_now = cur.stall_rx;
					chunk_ch.data_word  <= cur.data;
					chunk_ch.mask_word  <= cur.mask;
					chunk_ch.valid_bits <= cur.count;
					chunk_ch.last_chunk <= cur.last;
					chunk_ch.valid      <= 1'b1;
				end else begin
					if (have_cur)
						gap_left--;
					chunk_ch.valid <= 1'b0;
				end
			end
			hold_req <= stall_now;
		end
	end

	// result monitor and ready generator
	int hold_left  = 0;
	int rx_wait    = 0;
	bit no_idle_rx = 1'b0;

	always @(posedge clk) begin : check_results
		packed_beat_t want;
		bit           rdy;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				words_seen++;
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("unexpected result beat: word=%h count=%0d last=%0b",
							result_ch.packed_word, result_ch.bit_count, result_ch.last_word);
				end else begin
					want = expected_words.pop_front();
					if (result_ch.packed_word !== want.word
							|| result_ch.bit_count !== bcmc_pkg::CNT_W'(want.count)
							|| result_ch.last_word !== want.last) begin
						errors++;
						if (errors <= MAX_REPORTS) begin
							$write("result mismatch: expected word=%h count=%0d last=%0b,",
								want.word, want.count, want.last);
							$display(" got word=%h count=%0d last=%0b",
								result_ch.packed_word, result_ch.bit_count,
								result_ch.last_word);
						end
					end
				end
				// switch between idling and back-to-back stretches now and then
				if (words_seen % 100 == 0)
					no_idle_rx = ($urandom_range(0, 2) == 0);
				rx_wait = no_idle_rx ? 0 : $urandom_range(0, 16);
			end
			if (hold_req)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			result_ch.ready <= rdy;
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((chunk_ch.valid && chunk_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("bit_column_mask_compaction_unit_tb: done, errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// reset, then wait for the stream to drain
	initial begin : run_control
		chunk_ch.valid      = 1'b0;
		chunk_ch.data_word  = '0;
		chunk_ch.mask_word  = '0;
		chunk_ch.valid_bits = '0;
		chunk_ch.last_chunk = 1'b0;
		result_ch.ready     = 1'b0;
		arst_n              = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(negedge clk);
		while (chunk_q.size() > 0 || have_cur || chunk_ch.valid || expected_words.size() > 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("bit_column_mask_compaction_unit_tb: done, clean");
		else
			$display("bit_column_mask_compaction_unit_tb: done, errors");
		$finish;
	end

endmodule

/* bit_column_mask_compaction_unit.f */
+incdir+rtl/core
rtl/core/bcmc_pkg.sv
rtl/core/bcmc_in_if.sv
rtl/core/bcmc_out_if.sv
rtl/core/bcmc_front.sv
rtl/core/bcmc_queue.sv
rtl/core/bcmc_back.sv
rtl/core/bit_column_mask_compaction_unit.sv
tb/bit_column_mask_compaction_unit_tb.sv
